// ===== hdl/rv64_pkg.sv =====
// Package for the RV64I execute unit: opcodes, request and result structs.
// No dependencies; used by every module of the block.
package rv64_pkg;

  // Operation codes in dispatch order.
  localparam logic [5:0] OP_ADD = 6'd0, OP_SUB = 6'd1, OP_SLL = 6'd2, OP_SLT = 6'd3,
    OP_SLTU = 6'd4, OP_XOR = 6'd5, OP_SRL = 6'd6, OP_SRA = 6'd7, OP_OR = 6'd8,
    OP_AND = 6'd9, OP_ADDW = 6'd10, OP_SLLW = 6'd11, OP_SRLW = 6'd12, OP_SUBW = 6'd13,
    OP_SRAW = 6'd14, OP_JALR = 6'd15, OP_LB = 6'd16, OP_LH = 6'd17, OP_LW = 6'd18,
    OP_LBU = 6'd19, OP_LHU = 6'd20, OP_ADDI = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23,
    OP_XORI = 6'd24, OP_ORI = 6'd25, OP_ANDI = 6'd26, OP_LWU = 6'd27, OP_LD = 6'd28,
    OP_SLLI = 6'd29, OP_SRLI = 6'd30, OP_SRAI = 6'd31, OP_ADDIW = 6'd32,
    OP_SLLIW = 6'd33, OP_SRLIW = 6'd34, OP_SRAIW = 6'd35, OP_SB = 6'd36, OP_SH = 6'd37,
    OP_SW = 6'd38, OP_SD = 6'd39, OP_BEQ = 6'd40, OP_BNE = 6'd41, OP_BLT = 6'd42,
    OP_BGE = 6'd43, OP_BLTU = 6'd44, OP_BGEU = 6'd45, OP_LUI = 6'd46, OP_AUIPC = 6'd47,
    OP_JAL = 6'd48, OP_NOP = 6'd49, OP_ECALL = 6'd50;

  typedef struct packed {
    logic [5:0]         req_type;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } rv64_req_t;

  typedef struct packed {
    logic [63:0] new_pc;
    logic        reg_write;
    logic [4:0]  write_index;
    logic [63:0] write_value;
    logic        branch_taken;
    logic        halted;
  } rv64_rsp_t;

  // Sign extension of the low 32 bits.
  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage

// ===== hdl/rv64i_execute_unit.sv =====
// Top level of the RV64I execute unit: register file, pc pair, data memory.
// Depends on rv64_pkg and rv64_alu.
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_ready  | rv64_req_t
//   out_     | output    | out_valid / out_ready| rv64_rsp_t
//   cfg_     | input     | cfg_we               | start_pc (64 bits)
//
// Two stages. Stage 1 is the accepting edge: it reads the register file and
// the eight memory byte lanes into registers. Stage 2 executes, writes back
// and loads the output register, from which the result is offered. With a
// ready receiver the unit takes one request per cycle, unless a load waits
// on a store. A request whose register sources depend on the one in stage 2
// gets the forwarded value. A load right after a store waits until the store
// has left stage 2. The pc pair is updated in stage 2, where the next request
// reads it. A stalled output holds stage 2 and with it the input.
// Reset is synchronous, active low, and clears the register file through
// per-entry valid bits. MEM_BYTES must be a power of two.
module rv64i_execute_unit import rv64_pkg::*; #(
  parameter int MEM_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rv64_req_t   in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output rv64_rsp_t   out_rsp,
  input  logic        cfg_we,
  input  logic [63:0] cfg_start_pc
);
  localparam int AW    = $clog2(MEM_BYTES);
  localparam int WW    = AW - 3;
  localparam int WORDS = MEM_BYTES / 8;

  // Register file memory with per-entry valid bits.
  logic [63:0] rf_mem [32];
  logic [31:0] rf_vld_r;

  logic [63:0] pc_r, npc_r;
  logic        halt_r;

  // Stage 1 -> stage 2 registers.
  logic        s2_vld_r;
  rv64_req_t   s2_req_r;
  logic [63:0] s2_a_raw_r, s2_b_raw_r;
  logic        s2_a_fw_r, s2_b_fw_r;
  logic [63:0] wb_val_r;

  // Stage 2 write-back bookkeeping used for forwarding.
  logic        wb_en;
  logic [4:0]  wb_idx;
  logic [63:0] wb_val;
  logic        st_en;
  logic        s2_adv;
  logic        out_free;

  // Output register.
  logic        out_vld_r;
  rv64_rsp_t   out_rsp_r;

  logic        hazard;
  logic        s1_take;

  // Stage 2 operand recovery.
  logic [63:0] a, b, imm, ea, sum_pi, res_alu, val, npc_new;
  logic        wr, taken, cond, is_ld;
  logic [AW-1:0] base;
  logic [63:0] ld_raw;

  // Stage 1 load address.
  logic [63:0]   s1_a;
  logic [AW-1:0] s1_base;
  logic [WW-1:0] s1_word;
  logic [2:0]    s1_off;

  // Byte-lane access: rows of eight bytes, lane k holds addresses with
  // (addr mod 8) == k.
  logic [WW-1:0]  st_word;
  logic [2:0]     st_off;
  logic [7:0]     st_len, st_mask;
  logic [15:0]    st_mask_dbl;
  logic [127:0]   st_dbl, ld_dbl;
  logic [63:0]    st_data;
  logic [63:0]    lane_q;

  assign imm = {{32{s2_req_r.immediate[31]}}, s2_req_r.immediate};
  assign a   = s2_a_fw_r ? wb_val_r : s2_a_raw_r;
  assign b   = s2_b_fw_r ? wb_val_r : s2_b_raw_r;

  // The load in stage 1 reads memory; a store in stage 2 would be too late.
  assign is_ld = (in_req.req_type >= OP_LB && in_req.req_type <= OP_LHU) ||
                 in_req.req_type == OP_LWU || in_req.req_type == OP_LD;
  assign hazard = s2_vld_r && st_en && is_ld;

  assign out_free = !out_vld_r || out_ready;
  assign s2_adv   = s2_vld_r && out_free;
  assign in_ready = (!s2_vld_r || out_free) && !hazard;
  assign s1_take  = in_valid && in_ready;

  rv64_alu u_alu (
    .op(s2_req_r.req_type), .a(a), .b(b), .imm(imm), .pc(pc_r), .res(res_alu)
  );

  assign ea     = a + imm;
  assign base   = ea[AW-1:0];
  assign sum_pi = pc_r + imm;

  // Reassemble load data: byte i comes from lane (base + i) mod 8.
  assign ld_dbl = {lane_q, lane_q} >> {base[2:0], 3'b000};
  assign ld_raw = ld_dbl[63:0];

  // Execute.
  always_comb begin
    wr    = 1'b1;
    taken = 1'b0;
    cond  = 1'b0;
    val   = res_alu;
    npc_new = npc_r;
    st_en = 1'b0;
    unique case (s2_req_r.req_type)
      OP_JALR: begin val = npc_r; taken = 1'b1; npc_new = ea & ~64'd1; end
      OP_JAL:  begin val = npc_r; taken = 1'b1; npc_new = sum_pi; end
      OP_LB:   val = {{56{ld_raw[7]}}, ld_raw[7:0]};
      OP_LH:   val = {{48{ld_raw[15]}}, ld_raw[15:0]};
      OP_LW:   val = sx32(ld_raw);
      OP_LBU:  val = {56'd0, ld_raw[7:0]};
      OP_LHU:  val = {48'd0, ld_raw[15:0]};
      OP_LWU:  val = {32'd0, ld_raw[31:0]};
      OP_LD:   val = ld_raw;
      OP_SB, OP_SH, OP_SW, OP_SD: begin wr = 1'b0; st_en = 1'b1; end
      OP_BEQ:  begin wr = 1'b0; cond = (a == b); end
      OP_BNE:  begin wr = 1'b0; cond = (a != b); end
      OP_BLT:  begin wr = 1'b0; cond = ($signed(a) < $signed(b)); end
      OP_BGE:  begin wr = 1'b0; cond = !($signed(a) < $signed(b)); end
      OP_BLTU: begin wr = 1'b0; cond = (a < b); end
      OP_BGEU: begin wr = 1'b0; cond = (a >= b); end
      OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
      OP_ADDW, OP_SLLW, OP_SRLW, OP_SUBW, OP_SRAW, OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI,
      OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_ADDIW, OP_SLLIW, OP_SRLIW,
      OP_SRAIW, OP_LUI, OP_AUIPC: wr = 1'b1;
      default: wr = 1'b0;
    endcase
    if (cond) begin
      taken = 1'b1;
      npc_new = sum_pi;
    end
    if (halt_r || s2_req_r.req_type == OP_ECALL) begin
      wr = 1'b0;
      st_en = 1'b0;
    end
  end

  assign wb_en  = s2_vld_r && wr && (s2_req_r.dest_reg != 5'd0);
  assign wb_idx = s2_req_r.dest_reg;
  assign wb_val = val;

  // Stage 1: register file reads and forwarding flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s1_take) begin
      s2_vld_r <= 1'b1;
    end else if (s2_adv) begin
      s2_vld_r <= 1'b0;
    end
    if (s1_take) begin
      s2_req_r   <= in_req;
      s2_a_raw_r <= rf_vld_r[in_req.src1_reg] ? rf_mem[in_req.src1_reg] : 64'd0;
      s2_b_raw_r <= rf_vld_r[in_req.src2_reg] ? rf_mem[in_req.src2_reg] : 64'd0;
      s2_a_fw_r  <= s2_adv && wb_en && wb_idx == in_req.src1_reg;
      s2_b_fw_r  <= s2_adv && wb_en && wb_idx == in_req.src2_reg;
      wb_val_r   <= wb_val;
    end else if (s2_adv) begin
      s2_a_fw_r <= 1'b0;
      s2_b_fw_r <= 1'b0;
    end
  end

  // Memory address for stage 1 loads uses the forwarded source when needed.
  assign s1_a = (s2_adv && wb_en && wb_idx == in_req.src1_reg) ? wb_val :
                (rf_vld_r[in_req.src1_reg] ? rf_mem[in_req.src1_reg] : 64'd0);
  assign s1_base = s1_a[AW-1:0] + in_req.immediate[AW-1:0];
  assign s1_word = s1_base[AW-1:3];
  assign s1_off  = s1_base[2:0];

  // Store lane data and byte enables, rotated to the starting lane.
  always_comb begin
    unique case (s2_req_r.req_type)
      OP_SB:   st_len = 8'h01;
      OP_SH:   st_len = 8'h03;
      OP_SW:   st_len = 8'h0F;
      default: st_len = 8'hFF;
    endcase
  end

  assign st_word     = base[AW-1:3];
  assign st_off      = base[2:0];
  assign st_mask_dbl = {st_len, st_len} << st_off;
  assign st_mask     = st_mask_dbl[15:8];
  assign st_dbl      = {b, b} << {st_off, 3'b000};
  assign st_data     = st_dbl[127:64];

  // Data memory: lanes below the starting lane fall in the following row.
  for (genvar k = 0; k < 8; k++) begin : g_lane
    logic [7:0]    lane_mem [WORDS];
    logic [7:0]    rd_r;
    logic [WW-1:0] rd_a, wr_a;

    assign rd_a = (3'(k) < s1_off) ? s1_word + WW'(1) : s1_word;
    assign wr_a = (3'(k) < st_off) ? st_word + WW'(1) : st_word;

    always_ff @(posedge clk) begin
      if (s2_adv && st_en && st_mask[k]) lane_mem[wr_a] <= st_data[8*k +: 8];
      if (s1_take) rd_r <= lane_mem[rd_a];
    end

    assign lane_q[8*k +: 8] = rd_r;
  end

  // Write back, pc update and output register.
  always_ff @(posedge clk) begin
    if (wb_en && s2_adv) rf_mem[wb_idx] <= wb_val;
    if (!rst_n) begin
      rf_vld_r  <= '0;
      pc_r      <= 64'd0;
      npc_r     <= 64'd4;
      halt_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pc_r  <= cfg_start_pc;
        npc_r <= cfg_start_pc + 64'd4;
      end else if (s2_adv && !halt_r) begin
        if (s2_req_r.req_type == OP_ECALL) begin
          pc_r   <= 64'd0;
          halt_r <= 1'b1;
        end else begin
          pc_r  <= npc_new;
          npc_r <= npc_new + 64'd4;
        end
      end
      if (wb_en && s2_adv) rf_vld_r[wb_idx] <= 1'b1;
      if (s2_adv) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
    end
    if (s2_adv) begin
      if (halt_r || s2_req_r.req_type == OP_ECALL) begin
        out_rsp_r <= '{new_pc: halt_r ? pc_r : 64'd0, reg_write: 1'b0,
                       write_index: 5'd0, write_value: 64'd0,
                       branch_taken: 1'b0, halted: 1'b1};
      end else begin
        out_rsp_r <= '{new_pc: npc_new, reg_write: wb_en,
                       write_index: wb_en ? wb_idx : 5'd0,
                       write_value: wb_en ? wb_val : 64'd0,
                       branch_taken: taken, halted: 1'b0};
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_rsp_r;

  // A halted unit never writes the register file.
  a_no_wb_halt: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !wb_en) else $error("register write after halt");
  // x0 never becomes valid.
  a_x0: assert property (@(posedge clk) disable iff (!rst_n)
    !rf_vld_r[0]) else $error("x0 written");
  // No request is taken while a load waits on a store ahead of it.
  a_haz: assert property (@(posedge clk) disable iff (!rst_n)
    hazard |-> !s1_take) else $error("load passed store");
endmodule

// ===== hdl/rv64_alu.sv =====
// Combinational ALU for register, immediate, word and shift operations.
// Depends on rv64_pkg.
module rv64_alu import rv64_pkg::*; (
  input  logic [5:0]  op,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] imm,
  input  logic [63:0] pc,
  output logic [63:0] res
);
  logic [63:0] a_w;
  logic [31:0] a_lo;

  assign a_w  = sx32(a);
  assign a_lo = a[31:0];

  // Result selection by operation.
  always_comb begin
    unique case (op)
      OP_ADD:   res = a + b;
      OP_SUB:   res = a - b;
      OP_SLL:   res = a << b[5:0];
      OP_SLT:   res = {63'd0, $signed(a) < $signed(b)};
      OP_SLTU:  res = {63'd0, a < b};
      OP_XOR:   res = a ^ b;
      OP_SRL:   res = a >> b[5:0];
      OP_SRA:   res = $unsigned($signed(a) >>> b[5:0]);
      OP_OR:    res = a | b;
      OP_AND:   res = a & b;
      OP_ADDW:  res = sx32(a + b);
      OP_SLLW:  res = sx32(a << b[4:0]);
      OP_SRLW:  res = sx32({32'd0, a_lo >> b[4:0]});
      OP_SUBW:  res = sx32(a - b);
      OP_SRAW:  res = sx32($unsigned($signed(a_w) >>> b[4:0]));
      OP_ADDI:  res = a + imm;
      OP_SLTI:  res = {63'd0, $signed(a) < $signed(imm)};
      OP_SLTIU: res = {63'd0, a < imm};
      OP_XORI:  res = a ^ imm;
      OP_ORI:   res = a | imm;
      OP_ANDI:  res = a & imm;
      OP_SLLI:  res = a << imm[5:0];
      OP_SRLI:  res = a >> imm[5:0];
      OP_SRAI:  res = $unsigned($signed(a) >>> imm[5:0]);
      OP_ADDIW: res = sx32(a + imm);
      OP_SLLIW: res = sx32(a << imm[4:0]);
      OP_SRLIW: res = sx32({32'd0, a_lo >> imm[4:0]});
      OP_SRAIW: res = sx32($unsigned($signed(a_w) >>> imm[4:0]));
      OP_LUI:   res = imm;
      OP_AUIPC: res = pc + imm;
      default:  res = 64'd0;
    endcase
  end
endmodule

// ===== sim/rv64i_execute_unit_test.sv =====
// Self-checking testbench for the RV64I execute unit: directed and random requests,
// a built-in predictor of the architectural state and randomized flow control.
// Depends on rv64_pkg and the rv64i_execute_unit RTL.
`timescale 1ns / 100ps

module rv64i_execute_unit_test;
  import rv64_pkg::*;

  localparam int MEM_SIZE = 32768;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  rv64_req_t in_req;
  logic      out_valid;
  logic      out_ready;
  rv64_rsp_t out_rsp;
  logic      cfg_we;
  logic [63:0] cfg_start_pc;

  rv64i_execute_unit #(.MEM_BYTES(MEM_SIZE)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_start_pc(cfg_start_pc)
  );

  // Architectural state as the predictor sees it.
  logic [63:0] arch_regs [0:31];
  logic [63:0] arch_pc;
  logic [63:0] arch_next_pc;
  logic [7:0]  arch_mem [0:MEM_SIZE-1];
  bit          arch_halted;

  rv64_rsp_t pending_results[$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_cycles;

  // Clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] sext_word(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Little-endian read; addresses wrap around the end of memory.
  function automatic logic [63:0] mem_load(input logic [63:0] addr, input int n);
    logic [63:0] v;
    logic [14:0] p;
    v = '0;
    for (int i = 0; i < n; i++) begin
      p = addr[14:0] + 15'(i);
      v[8*i +: 8] = arch_mem[p];
    end
    return v;
  endfunction

  function automatic void mem_store(input logic [63:0] addr, input int n,
                                    input logic [63:0] v);
    logic [14:0] p;
    for (int i = 0; i < n; i++) begin
      p = addr[14:0] + 15'(i);
      arch_mem[p] = v[8*i +: 8];
    end
  endfunction

  // Executes one request on the architectural state and returns its result.
  function automatic rv64_rsp_t exec_instr(input rv64_req_t r);
    rv64_rsp_t rsp;
    logic [63:0] a, b, imm, val, npc, ea, ld;
    logic signed [63:0] sw;
    bit wr, taken, cond;
    rsp = '0;
    if (arch_halted) begin
      rsp.new_pc = arch_pc;
      rsp.halted = 1'b1;
      return rsp;
    end
    a = arch_regs[r.src1_reg];
    b = arch_regs[r.src2_reg];
    imm = {{32{r.immediate[31]}}, r.immediate};
    ea = a + imm;
    npc = arch_next_pc;
    val = '0;
    wr = 1'b1;
    taken = 1'b0;
    cond = 1'b0;
    case (r.req_type)
      OP_ADD:   val = a + b;
      OP_SUB:   val = a - b;
      OP_SLL:   val = a << b[5:0];
      OP_SLT:   val = 64'($signed(a) < $signed(b));
      OP_SLTU:  val = 64'(a < b);
      OP_XOR:   val = a ^ b;
      OP_SRL:   val = a >> b[5:0];
      OP_SRA:   val = $signed(a) >>> b[5:0];
      OP_OR:    val = a | b;
      OP_AND:   val = a & b;
      OP_ADDW:  val = sext_word(a + b);
      OP_SLLW:  val = sext_word(a << b[4:0]);
      OP_SRLW:  val = sext_word({32'b0, a[31:0]} >> b[4:0]);
      OP_SUBW:  val = sext_word(a - b);
      OP_SRAW: begin
        sw = sext_word(a);
        val = sext_word(sw >>> b[4:0]);
      end
      OP_JALR: begin
        val = arch_next_pc;
        taken = 1'b1;
        npc = ea & ~64'd1;
      end
      OP_LB: begin
        ld = mem_load(ea, 1);
        val = {{56{ld[7]}}, ld[7:0]};
      end
      OP_LH: begin
        ld = mem_load(ea, 2);
        val = {{48{ld[15]}}, ld[15:0]};
      end
      OP_LW:    val = sext_word(mem_load(ea, 4));
      OP_LBU:   val = mem_load(ea, 1);
      OP_LHU:   val = mem_load(ea, 2);
      OP_ADDI:  val = ea;
      OP_SLTI:  val = 64'($signed(a) < $signed(imm));
      OP_SLTIU: val = 64'(a < imm);
      OP_XORI:  val = a ^ imm;
      OP_ORI:   val = a | imm;
      OP_ANDI:  val = a & imm;
      OP_LWU:   val = mem_load(ea, 4);
      OP_LD:    val = mem_load(ea, 8);
      OP_SLLI:  val = a << imm[5:0];
      OP_SRLI:  val = a >> imm[5:0];
      OP_SRAI:  val = $signed(a) >>> imm[5:0];
      OP_ADDIW: val = sext_word(ea);
      OP_SLLIW: val = sext_word(a << imm[4:0]);
      OP_SRLIW: val = sext_word({32'b0, a[31:0]} >> imm[4:0]);
      OP_SRAIW: begin
        sw = sext_word(a);
        val = sext_word(sw >>> imm[4:0]);
      end
      OP_SB: begin mem_store(ea, 1, b); wr = 1'b0; end
      OP_SH: begin mem_store(ea, 2, b); wr = 1'b0; end
      OP_SW: begin mem_store(ea, 4, b); wr = 1'b0; end
      OP_SD: begin mem_store(ea, 8, b); wr = 1'b0; end
      OP_BEQ:   begin cond = (a == b); wr = 1'b0; end
      OP_BNE:   begin cond = (a != b); wr = 1'b0; end
      OP_BLT:   begin cond = ($signed(a) < $signed(b)); wr = 1'b0; end
      OP_BGE:   begin cond = !($signed(a) < $signed(b)); wr = 1'b0; end
      OP_BLTU:  begin cond = (a < b); wr = 1'b0; end
      OP_BGEU:  begin cond = (a >= b); wr = 1'b0; end
      OP_LUI:   val = imm;
      OP_AUIPC: val = arch_pc + imm;
      OP_JAL: begin
        val = arch_next_pc;
        taken = 1'b1;
        npc = arch_pc + imm;
      end
      OP_ECALL: begin
        arch_pc = '0;
        arch_halted = 1'b1;
        rsp.halted = 1'b1;
        return rsp;
      end
      default:  wr = 1'b0;
    endcase
    if (cond) begin
      taken = 1'b1;
      npc = arch_pc + imm;
    end
    if (r.dest_reg == 5'd0) wr = 1'b0;
    if (wr) arch_regs[r.dest_reg] = val;
    arch_pc = npc;
    arch_next_pc = npc + 64'd4;
    rsp.new_pc = arch_pc;
    rsp.reg_write = wr;
    rsp.write_index = wr ? r.dest_reg : 5'd0;
    rsp.write_value = wr ? val : 64'd0;
    rsp.branch_taken = taken;
    return rsp;
  endfunction

  function automatic rv64_req_t mk(input logic [5:0] op, input logic [4:0] rd,
                                   input logic [4:0] rs1, input logic [4:0] rs2,
                                   input logic [31:0] imm);
    rv64_req_t r;
    r.req_type = op;
    r.dest_reg = rd;
    r.src1_reg = rs1;
    r.src2_reg = rs2;
    r.immediate = imm;
    return r;
  endfunction

  // Random request. Loads are steered into the region that has been stored:
  // bytes 32764..32767 and 0..63, so wrapping accesses occur too.
  function automatic rv64_req_t rand_req();
    rv64_req_t r;
    int n, off;
    logic [14:0] target;
    r = mk($urandom_range(0, 19) == 0 ? 6'($urandom_range(51, 63))
                                      : 6'($urandom_range(0, 49)),
           5'($urandom), 5'($urandom), 5'($urandom), $urandom());
    case (r.req_type)
      OP_LB, OP_LBU: n = 1;
      OP_LH, OP_LHU: n = 2;
      OP_LW, OP_LWU: n = 4;
      OP_LD:         n = 8;
      default:       n = 0;
    endcase
    if (n != 0) begin
      off = $urandom_range(0, 68 - n);
      target = 15'(32764 + off);
      r.immediate[14:0] = target - arch_regs[r.src1_reg][14:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %h expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offers one request and predicts its result once it is accepted.
  task automatic send_request(input rv64_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(exec_instr(r));
  endtask

  // Stops offering and waits until every result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_start_pc <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    arch_pc = v;
    arch_next_pc = v + 64'd4;
  endtask

  // Result checker.
  always @(posedge clk) begin
    rv64_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, new_pc", out_rsp.new_pc, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_rsp.new_pc !== want.new_pc)
          report_mismatch("new_pc", out_rsp.new_pc, want.new_pc);
        if (out_rsp.reg_write !== want.reg_write)
          report_mismatch("reg_write", out_rsp.reg_write, want.reg_write);
        if (out_rsp.write_index !== want.write_index)
          report_mismatch("write_index", out_rsp.write_index, want.write_index);
        if (out_rsp.write_value !== want.write_value)
          report_mismatch("write_value", out_rsp.write_value, want.write_value);
        if (out_rsp.branch_taken !== want.branch_taken)
          report_mismatch("branch_taken", out_rsp.branch_taken, want.branch_taken);
        if (out_rsp.halted !== want.halted)
          report_mismatch("halted", out_rsp.halted, want.halted);
      end
    end
  end

  // Result side flow control, with an optional long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Register extremes, stores filling the load region, and special cases.
  task automatic test_directed();
    write_start_pc(64'h0000_0000_0000_1000);
    send_request(mk(OP_LUI, 5'd1, 5'd0, 5'd0, 32'h8000_0000));
    send_request(mk(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_FFFF));
    send_request(mk(OP_ADDI, 5'd3, 5'd0, 5'd0, 32'h7FFF_FFFF));
    send_request(mk(OP_SLLI, 5'd4, 5'd2, 5'd0, 32'd63));
    for (int i = 0; i < 8; i++)
      send_request(mk(OP_SD, 5'd0, 5'd0, 5'(1 + i % 4), 32'(8 * i)));
    // Store that wraps around the top of memory, then read it back.
    send_request(mk(OP_SD, 5'd0, 5'd0, 5'd1, 32'd32764));
    send_request(mk(OP_LD, 5'd5, 5'd0, 5'd0, 32'd32764));
    send_request(mk(OP_LB, 5'd6, 5'd0, 5'd0, 32'd11));
    send_request(mk(OP_LHU, 5'd7, 5'd0, 5'd0, 32'd10));
    // Writes to x0 are dropped.
    send_request(mk(OP_ADDI, 5'd0, 5'd2, 5'd0, 32'd5));
    // JALR whose destination is also its source.
    send_request(mk(OP_JALR, 5'd3, 5'd3, 5'd0, 32'h8000_0001));
    send_request(mk(OP_SRAW, 5'd8, 5'd1, 5'd2, 32'd0));
    send_request(mk(OP_SRAIW, 5'd9, 5'd3, 5'd0, 32'd31));
    send_request(mk(OP_BGE, 5'd0, 5'd1, 5'd2, 32'hFFFF_FFF0));
    send_request(mk(OP_BLTU, 5'd0, 5'd1, 5'd2, 32'h7FFF_FFFC));
    send_request(mk(OP_JAL, 5'd31, 5'd0, 5'd0, 32'h8000_0000));
    send_request(mk(OP_AUIPC, 5'd10, 5'd0, 5'd0, 32'h1234_5000));
    send_request(mk(6'd63, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF));
    drain();
  endtask

  task automatic test_random(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_request(rand_req());
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Result side held off long enough for the unit to fill and stall its input.
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_request(rand_req());
    drain();
  endtask

  // Boot pc at its extremes and at a random value, with requests run from each.
  task automatic test_start_pc();
    logic [63:0] values [4];
    values = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFC,
               {$urandom(), $urandom()}};
    foreach (values[i]) begin
      write_start_pc(values[i]);
      test_random(25, 0, 0);
    end
  endtask

  // ECALL halts the unit; later requests report the halted state only.
  task automatic test_halt();
    send_request(mk(OP_ECALL, 5'd1, 5'd2, 5'd3, $urandom()));
    for (int i = 0; i < 15; i++) send_request(rand_req());
    drain();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    arch_pc = '0;
    arch_next_pc = 64'd4;
    arch_halted = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_req <= '0;
    cfg_we <= 1'b0;
    cfg_start_pc <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(200, 0, 0);
    test_random(150, 84, 0);
    test_random(150, 0, 84);
    test_random(250, 30, 30);
    test_backpressure();
    test_start_pc();
    test_halt();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rv64i_execute_unit: match");
    end else begin
      $display("rv64i_execute_unit: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("rv64i_execute_unit: mismatch");
    $finish;
  end

endmodule
